@@ design/egapq_pkg.sv @@
// ----------------------------------------------------------------------------
// egapq_pkg
// Shared types and constants for the EGA palette quantizer with planar packing.
// ----------------------------------------------------------------------------
package egapq_pkg;

   localparam int unsigned CHAN_W          = 8;
   localparam int unsigned NUM_COLORS      = 16;
   localparam int unsigned INDEX_W         = 4;
   localparam int unsigned NUM_PLANES      = 4;
   localparam int unsigned DIST_W          = 10;
   localparam int unsigned BYTE_INDEX_W    = 17;
   localparam int unsigned SLOT_W          = 3;
   localparam int unsigned MAX_PLANE_BYTES = 131072;

   typedef logic [CHAN_W-1:0]       chan_type;
   typedef logic [INDEX_W-1:0]      index_type;
   typedef logic [DIST_W-1:0]       dist_type;
   typedef logic [BYTE_INDEX_W-1:0] byte_index_type;
   typedef logic [SLOT_W-1:0]       slot_type;
   typedef logic [7:0]              plane_byte_type;

   typedef struct packed {
      chan_type red;
      chan_type green;
      chan_type blue;
   } rgb_type;

   // Fixed 16-color palette, indexed by palette code
   localparam rgb_type PALETTE [NUM_COLORS] = '{
      '{8'h00, 8'h00, 8'h00}, '{8'h00, 8'h00, 8'hAA},
      '{8'h00, 8'hAA, 8'h00}, '{8'h00, 8'hAA, 8'hAA},
      '{8'hAA, 8'h00, 8'h00}, '{8'hAA, 8'h00, 8'hAA},
      '{8'hAA, 8'h55, 8'h00}, '{8'hAA, 8'hAA, 8'hAA},
      '{8'h55, 8'h55, 8'h55}, '{8'h55, 8'h55, 8'hFF},
      '{8'h55, 8'hFF, 8'h55}, '{8'h55, 8'hFF, 8'hFF},
      '{8'hFF, 8'h55, 8'h55}, '{8'hFF, 8'h55, 8'hFF},
      '{8'hFF, 8'hFF, 8'h55}, '{8'hFF, 8'hFF, 8'hFF}
   };

   // Last slot of a byte; the pixel there completes the byte
   localparam slot_type LAST_SLOT = slot_type'(7);
   localparam byte_index_type BYTE_WRAP = byte_index_type'(MAX_PLANE_BYTES - 1);

endpackage

@@ design/egapq_if.sv @@
// ----------------------------------------------------------------------------
// egapq_req_if / egapq_rsp_if
// Valid/ready channels for pixels in and packed plane bytes out.
// ----------------------------------------------------------------------------
interface egapq_req_if
   import egapq_pkg::*;
   ();
   logic     valid;
   logic     ready;
   chan_type red;
   chan_type green;
   chan_type blue;
   logic     last_pixel;

   modport source (output valid, red, green, blue, last_pixel, input ready);
   modport sink   (input valid, red, green, blue, last_pixel, output ready);
endinterface

interface egapq_rsp_if
   import egapq_pkg::*;
   ();
   logic           valid;
   logic           ready;
   plane_byte_type plane0_byte;
   plane_byte_type plane1_byte;
   plane_byte_type plane2_byte;
   plane_byte_type plane3_byte;
   byte_index_type byte_index;
   logic           image_done;

   modport source (output valid, plane0_byte, plane1_byte, plane2_byte, plane3_byte,
                   byte_index, image_done, input ready);
   modport sink   (input valid, plane0_byte, plane1_byte, plane2_byte, plane3_byte,
                   byte_index, image_done, output ready);
endinterface

@@ design/egapq_nearest.sv @@
// ----------------------------------------------------------------------------
// egapq_nearest
// Nearest palette color by sum of absolute channel differences; on a tie the
// lowest palette index wins. Sixteen distance units feed a four-level min tree.
// ----------------------------------------------------------------------------
module egapq_nearest
   import egapq_pkg::*;
(
   input  rgb_type   pixel,
   output index_type nearest_index
);

   function automatic dist_type abs_diff(input chan_type a, input chan_type b);
      return (a > b) ? dist_type'(a - b) : dist_type'(b - a);
   endfunction

   dist_type  dist_l0 [16];
   dist_type  dist_l1 [8];
   index_type idx_l1  [8];
   dist_type  dist_l2 [4];
   index_type idx_l2  [4];
   dist_type  dist_l3 [2];
   index_type idx_l3  [2];

   // Compute one distance per palette entry
   always_comb begin
      for (int k = 0; k < 16; k++) begin
         dist_l0[k] = abs_diff(pixel.red,   PALETTE[k].red)
                    + abs_diff(pixel.green, PALETTE[k].green)
                    + abs_diff(pixel.blue,  PALETTE[k].blue);
      end
   end

   // Reduce pairwise; the higher index wins only when strictly closer
   always_comb begin
      for (int k = 0; k < 8; k++) begin
         if (dist_l0[2*k+1] < dist_l0[2*k]) begin
            dist_l1[k] = dist_l0[2*k+1];
            idx_l1[k]  = index_type'(2*k+1);
         end else begin
            dist_l1[k] = dist_l0[2*k];
            idx_l1[k]  = index_type'(2*k);
         end
      end
      for (int k = 0; k < 4; k++) begin
         if (dist_l1[2*k+1] < dist_l1[2*k]) begin
            dist_l2[k] = dist_l1[2*k+1];
            idx_l2[k]  = idx_l1[2*k+1];
         end else begin
            dist_l2[k] = dist_l1[2*k];
            idx_l2[k]  = idx_l1[2*k];
         end
      end
      for (int k = 0; k < 2; k++) begin
         if (dist_l2[2*k+1] < dist_l2[2*k]) begin
            dist_l3[k] = dist_l2[2*k+1];
            idx_l3[k]  = idx_l2[2*k+1];
         end else begin
            dist_l3[k] = dist_l2[2*k];
            idx_l3[k]  = idx_l2[2*k];
         end
      end
   end

   assign nearest_index = (dist_l3[1] < dist_l3[0]) ? idx_l3[1] : idx_l3[0];

endmodule

@@ design/ega_palette_quantize_planar_pack_top.sv @@
// ----------------------------------------------------------------------------
// ega_palette_quantize_planar_pack_top
// EGA 16-color quantizer that packs palette indices into four bit planes.
// ----------------------------------------------------------------------------
// Takes one RGB pixel per clock and returns one transaction of four plane
// bytes for every eight pixels, or earlier at a pixel marked last_pixel (low
// bits padded with zeros, image_done set, byte index restarts at zero).
// A pixel sits in an input register; the nearest-color search and the plane
// accumulators work on it in the same cycle, and a result sits in an output
// register. Throughput is one pixel per clock; the input stalls only when a
// finished result is still waiting on rsp and another one is due.
// ----------------------------------------------------------------------------
module ega_palette_quantize_planar_pack_top
   import egapq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   egapq_req_if.sink   req,
   egapq_rsp_if.source rsp
);

   // Input register
   logic      pix_valid_ff;
   rgb_type   pix_ff;
   logic      pix_last_ff;
   logic      pix_ready;
   index_type nearest_in;

   // Packing state
   slot_type       slot_ff;
   plane_byte_type acc_ff [NUM_PLANES];
   plane_byte_type acc_in [NUM_PLANES];
   byte_index_type count_ff;
   logic           emit;
   logic           pack_fire;

   // Output register
   logic           out_valid_ff;
   logic           out_ready;
   plane_byte_type out_plane_ff [NUM_PLANES];
   byte_index_type out_index_ff;
   logic           out_done_ff;

   egapq_nearest u_nearest (
      .pixel         (pix_ff),
      .nearest_index (nearest_in)
   );

   // Backpressure: the input register frees up unless a byte is due and blocked
   assign out_ready = !out_valid_ff || rsp.ready;
   assign emit      = (slot_ff == LAST_SLOT) || pix_last_ff;
   assign pix_ready = !pix_valid_ff || !emit || out_ready;
   assign req.ready = pix_ready;
   assign pack_fire = pix_valid_ff && pix_ready;

   // Merge the current index bits into the accumulators at this slot
   always_comb begin
      for (int p = 0; p < NUM_PLANES; p++) begin
         acc_in[p] = acc_ff[p] | (plane_byte_type'(nearest_in[p]) << (LAST_SLOT - slot_ff));
      end
   end

   // Advance the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         pix_valid_ff <= 1'b0;
      end else if (pix_ready) begin
         pix_valid_ff <= req.valid;
      end
      if (pix_ready && req.valid) begin
         pix_ff      <= '{red: req.red, green: req.green, blue: req.blue};
         pix_last_ff <= req.last_pixel;
      end
   end

   // Accumulate planes; emit a byte when full or at the image end
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= '0;
         count_ff <= '0;
         for (int p = 0; p < NUM_PLANES; p++) begin
            acc_ff[p] <= '0;
         end
      end else if (pack_fire) begin
         if (emit) begin
            slot_ff <= '0;
            for (int p = 0; p < NUM_PLANES; p++) begin
               acc_ff[p] <= '0;
            end
            if (pix_last_ff || (count_ff == BYTE_WRAP)) begin
               count_ff <= '0;
            end else begin
               count_ff <= count_ff + byte_index_type'(1);
            end
         end else begin
            slot_ff <= slot_ff + slot_type'(1);
            acc_ff  <= acc_in;
         end
      end
   end

   // Hold result until the sink takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (pack_fire && emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
      if (pack_fire && emit) begin
         out_plane_ff <= acc_in;
         out_index_ff <= count_ff;
         out_done_ff  <= pix_last_ff;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.plane0_byte = out_plane_ff[0];
   assign rsp.plane1_byte = out_plane_ff[1];
   assign rsp.plane2_byte = out_plane_ff[2];
   assign rsp.plane3_byte = out_plane_ff[3];
   assign rsp.byte_index  = out_index_ff;
   assign rsp.image_done  = out_done_ff;

endmodule
